@@ sv/slcan_pkg.sv @@
// Shared types and constants for the SLCAN ASCII frame parser.
// Used by slcan_ascii_frame_parser and slcan_rq; depends on nothing.
package slcan_pkg;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    localparam int DATA_LIMIT_W = 7;

    typedef enum logic [2:0] {
        FT_NONE,
        FT_STD,
        FT_EXT,
        FT_RSTD,
        FT_REXT,
        FT_FSTD,
        FT_FEXT,
        FT_ERR
    } frame_type_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_FORMAT,
        ST_TRUNCATED,
        ST_ERR_DROPPED
    } status_t;

    typedef enum logic [2:0] {
        EK_NONE,
        EK_BIT,
        EK_STUFF,
        EK_CRC,
        EK_FORM,
        EK_ACK
    } error_kind_t;

    localparam logic [7:0] FLAG_BIT   = 8'h01;
    localparam logic [7:0] FLAG_STUFF = 8'h02;
    localparam logic [7:0] FLAG_CRC   = 8'h04;
    localparam logic [7:0] FLAG_FORM  = 8'h08;
    localparam logic [7:0] FLAG_ACK   = 8'h10;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [5:0]  byte_index;
        logic [31:0] frame_id;
        logic [3:0]  dlc_code;
        logic        is_extended;
        logic        is_remote;
        logic        is_fd;
        logic        is_error_frame;
        logic [2:0]  error_kind;
        logic [1:0]  status;
        logic        last;
    } result_t;

    // count is 0, 1 or 2; second is written only when count is 2
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } rq_push_t;

    function automatic logic [DATA_LIMIT_W-1:0] fd_size(input logic [3:0] dlc);
        logic [DATA_LIMIT_W-1:0] n;
        begin
            unique case (dlc)
                4'd9:    n = 7'd12;
                4'd10:   n = 7'd16;
                4'd11:   n = 7'd20;
                4'd12:   n = 7'd24;
                4'd13:   n = 7'd32;
                4'd14:   n = 7'd48;
                4'd15:   n = 7'd64;
                default: n = {3'd0, dlc};
            endcase
            return n;
        end
    endfunction

endpackage

@@ sv/slcan_rq.sv @@
// Result queue of the SLCAN parser: takes up to two results a cycle, hands out one.
// Depends on slcan_pkg (result_t, rq_push_t, RQ_DEPTH, a power of two).
module slcan_rq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  slcan_pkg::rq_push_t       push,
    input  logic                      pop,
    output slcan_pkg::result_t        head,
    output logic [slcan_pkg::RQ_AW:0] count
);
    import slcan_pkg::*;

    result_t            entry_reg [RQ_DEPTH];
    logic [RQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RQ_AW:0]     count_reg, count_next;
    logic [RQ_AW-1:0]   wr_ptr_second;

    assign wr_ptr_second = wr_ptr_reg + 1'b1;
    assign wr_ptr_next   = wr_ptr_reg + RQ_AW'(push.count);
    assign rd_ptr_next   = rd_ptr_reg + RQ_AW'(pop);
    assign count_next    = count_reg + (RQ_AW+1)'(push.count) - (RQ_AW+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_second] <= push.second;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

@@ sv/slcan_ascii_frame_parser.sv @@
// SLCAN ASCII frame parser top level: character decode, header and payload state.
// Depends on slcan_pkg and slcan_rq.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one ASCII character per transfer, with
//   end_of_message set on the final character of a message (t, T, r, R, d, D or e).
//   Output channel (out_valid/out_ready) carries one result per transfer: a data
//   byte (kind 0) as soon as its second hex digit is in, and one status result
//   (kind 1) for the character that ends the message. A character causes at most
//   two results; last marks the final one.
//   A result is offered the cycle after its character's transfer when no earlier
//   result is still waiting.
//   Throughput: one character per cycle while in_ready is high; state update is a
//   single pass over small registers. Results wait in a four-entry queue, and
//   in_ready stays high while at least two entries are free, so a stalled receiver
//   stops input once three results are waiting.
//   Reset: parser state returns to the start of a message and the queue empties;
//   after every status result the parser state returns there as well.
module slcan_ascii_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_in,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  data_byte,
    output logic [5:0]  byte_index,
    output logic [31:0] frame_id,
    output logic [3:0]  dlc_code,
    output logic        is_extended,
    output logic        is_remote,
    output logic        is_fd,
    output logic        is_error_frame,
    output logic [2:0]  error_kind,
    output logic [1:0]  status,
    output logic        last
);
    import slcan_pkg::*;

    localparam logic [7:0] CH_LC_T = 8'h74;
    localparam logic [7:0] CH_UC_T = 8'h54;
    localparam logic [7:0] CH_LC_R = 8'h72;
    localparam logic [7:0] CH_UC_R = 8'h52;
    localparam logic [7:0] CH_LC_D = 8'h64;
    localparam logic [7:0] CH_UC_D = 8'h44;
    localparam logic [7:0] CH_LC_E = 8'h65;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_UC_A = 8'h41;
    localparam logic [7:0] CH_UC_F = 8'h46;
    localparam logic [7:0] CH_LC_A = 8'h61;
    localparam logic [7:0] CH_LC_F = 8'h66;
    localparam logic [7:0] CC_MAX  = 8'hFF;
    localparam logic [7:0] ERR_HDR_LEN = 8'd9;
    localparam logic [DATA_LIMIT_W-1:0] ERR_PAYLOAD_CAP = 7'd64;

    logic [7:0]              cc_reg, cc_next;
    frame_type_t             ft_reg, ft_next;
    logic [31:0]             id_reg, id_next;
    logic                    hb_reg, hb_next;
    logic [3:0]              dlc_reg, dlc_next;
    logic [3:0]              hn_reg, hn_next;
    logic [7:0]              first_reg, first_next;
    logic [DATA_LIMIT_W-1:0] bd_reg, bd_next;
    logic                    phase_reg, phase_next;

    logic                    in_xfer;
    logic                    hex_ok;
    logic [3:0]              hex_v;
    logic [7:0]              id_len;
    logic [7:0]              id_len_n;
    logic [DATA_LIMIT_W-1:0] limit_cur;
    logic [DATA_LIMIT_W-1:0] limit_n;
    logic [7:0]              need_n;
    logic [7:0]              byte_v;
    logic                    emit_data;
    status_t                 st_code;
    result_t                 data_res;
    result_t                 stat_res;
    rq_push_t                push;
    result_t                 head;
    logic [RQ_AW:0]          rq_count;

    function automatic frame_type_t decode_type(input logic [7:0] c);
        frame_type_t t;
        begin
            unique case (c)
                CH_LC_T: t = FT_STD;
                CH_UC_T: t = FT_EXT;
                CH_LC_R: t = FT_RSTD;
                CH_UC_R: t = FT_REXT;
                CH_LC_D: t = FT_FSTD;
                CH_UC_D: t = FT_FEXT;
                CH_LC_E: t = FT_ERR;
                default: t = FT_NONE;
            endcase
            return t;
        end
    endfunction

    function automatic logic [7:0] id_digits(input frame_type_t t);
        return (t == FT_STD || t == FT_RSTD || t == FT_FSTD) ? 8'd3 : 8'd8;
    endfunction

    function automatic logic [DATA_LIMIT_W-1:0] payload_limit(input frame_type_t t,
                                                              input logic [3:0] dlc);
        logic [DATA_LIMIT_W-1:0] n;
        begin
            unique case (t)
                FT_STD, FT_EXT:   n = {3'd0, dlc};
                FT_FSTD, FT_FEXT: n = fd_size(dlc);
                FT_ERR:           n = ERR_PAYLOAD_CAP;
                default:          n = '0;
            endcase
            return n;
        end
    endfunction

    always_comb
    begin
        hex_ok = 1'b1;
        hex_v  = 4'd0;
        priority if (char_in >= CH_0 && char_in <= CH_9)
        begin
            hex_v = 4'(char_in - CH_0);
        end
        else if (char_in >= CH_UC_A && char_in <= CH_UC_F)
        begin
            hex_v = 4'(char_in - CH_UC_A + 8'd10);
        end
        else if (char_in >= CH_LC_A && char_in <= CH_LC_F)
        begin
            hex_v = 4'(char_in - CH_LC_A + 8'd10);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign id_len    = id_digits(ft_reg);
    assign limit_cur = payload_limit(ft_reg, dlc_reg);
    assign byte_v    = {hn_reg, hex_v};

    // next parser state for the character on the input
    always_comb
    begin
        ft_next    = ft_reg;
        id_next    = id_reg;
        hb_next    = hb_reg;
        dlc_next   = dlc_reg;
        hn_next    = hn_reg;
        first_next = first_reg;
        bd_next    = bd_reg;
        phase_next = phase_reg;
        emit_data  = 1'b0;
        if (cc_reg == 8'd0)
        begin
            ft_next = decode_type(char_in);
        end
        else if (ft_reg != FT_NONE)
        begin
            if (cc_reg <= id_len)
            begin
                hb_next = hb_reg | ~hex_ok;
                id_next = {id_reg[27:0], hex_v};
            end
            else if (cc_reg == id_len + 8'd1 && ft_reg != FT_ERR)
            begin
                hb_next  = hb_reg | ~hex_ok | (ft_reg <= FT_REXT && hex_v > 4'd8);
                dlc_next = hex_v;
            end
            else if (!phase_reg)
            begin
                hn_next    = hex_v;
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                if (bd_reg < limit_cur)
                begin
                    if (bd_reg == '0)
                    begin
                        first_next = byte_v;
                    end
                    emit_data = ~hb_reg;
                    bd_next   = bd_reg + 1'b1;
                end
            end
        end
        cc_next = (cc_reg == CC_MAX) ? cc_reg : cc_reg + 8'd1;
    end

    assign id_len_n = id_digits(ft_next);
    assign limit_n  = payload_limit(ft_next, dlc_next);
    assign need_n   = id_len_n + 8'd2 + {limit_n, 1'b0};

    always_comb
    begin
        priority if (cc_next < 8'd2 || ft_next == FT_NONE)
        begin
            st_code = ST_BAD_FORMAT;
        end
        else if (ft_next == FT_ERR)
        begin
            priority if (cc_next < ERR_HDR_LEN) st_code = ST_TRUNCATED;
            else if (hb_next)                   st_code = ST_BAD_FORMAT;
            else if (phase_next)                st_code = ST_ERR_DROPPED;
            else                                st_code = ST_OK;
        end
        else
        begin
            priority if (cc_next < id_len_n + 8'd2) st_code = ST_TRUNCATED;
            else if (hb_next)                        st_code = ST_BAD_FORMAT;
            else if (ft_next != FT_RSTD && ft_next != FT_REXT && cc_next < need_n)
                st_code = ST_TRUNCATED;
            else
                st_code = ST_OK;
        end
    end

    always_comb
    begin
        stat_res        = '0;
        stat_res.kind   = 1'b1;
        stat_res.status = st_code;
        stat_res.last   = 1'b1;
        if (st_code == ST_OK || st_code == ST_ERR_DROPPED)
        begin
            stat_res.frame_id    = id_next;
            stat_res.is_extended = (ft_next == FT_EXT || ft_next == FT_REXT ||
                                    ft_next == FT_FEXT || ft_next == FT_ERR);
            stat_res.is_remote   = (ft_next == FT_RSTD || ft_next == FT_REXT);
            stat_res.is_fd       = (ft_next == FT_FSTD || ft_next == FT_FEXT);
            if (ft_next == FT_ERR)
            begin
                stat_res.is_error_frame = 1'b1;
                if (st_code == ST_OK && bd_next != '0)
                begin
                    priority if ((first_next & FLAG_BIT) != '0)   stat_res.error_kind = EK_BIT;
                    else if ((first_next & FLAG_STUFF) != '0)     stat_res.error_kind = EK_STUFF;
                    else if ((first_next & FLAG_CRC) != '0)       stat_res.error_kind = EK_CRC;
                    else if ((first_next & FLAG_FORM) != '0)      stat_res.error_kind = EK_FORM;
                    else if ((first_next & FLAG_ACK) != '0)       stat_res.error_kind = EK_ACK;
                    else                                          stat_res.error_kind = EK_NONE;
                end
                else
                begin
                    stat_res.error_kind = (id_next[2:0] <= 3'd4) ? id_next[2:0] + 3'd1
                                                                 : EK_NONE;
                end
            end
            else
            begin
                stat_res.dlc_code = dlc_next;
            end
        end
    end

    always_comb
    begin
        data_res            = '0;
        data_res.data_byte  = byte_v;
        data_res.byte_index = bd_reg[5:0];
        data_res.last       = ~end_of_message;
    end

    assign in_xfer     = in_valid & in_ready;
    assign push.count  = in_xfer ? 2'(emit_data) + 2'(end_of_message) : 2'd0;
    assign push.first  = emit_data ? data_res : stat_res;
    assign push.second = stat_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg    <= '0;
            ft_reg    <= FT_NONE;
            id_reg    <= '0;
            hb_reg    <= 1'b0;
            dlc_reg   <= '0;
            hn_reg    <= '0;
            first_reg <= '0;
            bd_reg    <= '0;
            phase_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            if (end_of_message)
            begin
                cc_reg    <= '0;
                ft_reg    <= FT_NONE;
                id_reg    <= '0;
                hb_reg    <= 1'b0;
                dlc_reg   <= '0;
                hn_reg    <= '0;
                first_reg <= '0;
                bd_reg    <= '0;
                phase_reg <= 1'b0;
            end
            else
            begin
                cc_reg    <= cc_next;
                ft_reg    <= ft_next;
                id_reg    <= id_next;
                hb_reg    <= hb_next;
                dlc_reg   <= dlc_next;
                hn_reg    <= hn_next;
                first_reg <= first_next;
                bd_reg    <= bd_next;
                phase_reg <= phase_next;
            end
        end
    end

    slcan_rq u_rq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (out_valid & out_ready),
        .head  (head),
        .count (rq_count)
    );

    assign in_ready       = (rq_count <= (RQ_AW+1)'(RQ_DEPTH - 2));
    assign out_valid      = (rq_count != '0);
    assign kind           = head.kind;
    assign data_byte      = head.data_byte;
    assign byte_index     = head.byte_index;
    assign frame_id       = head.frame_id;
    assign dlc_code       = head.dlc_code;
    assign is_extended    = head.is_extended;
    assign is_remote      = head.is_remote;
    assign is_fd          = head.is_fd;
    assign is_error_frame = head.is_error_frame;
    assign error_kind     = head.error_kind;
    assign status         = head.status;
    assign last           = head.last;

`ifndef SYNTH
    a_rq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        rq_count <= (RQ_AW+1)'(RQ_DEPTH))
        else $error("result queue overflow");

    a_eom_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && end_of_message) |=> (cc_reg == 8'd0 && ft_reg == FT_NONE))
        else $error("parser state not cleared after end of message");

    a_bad_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind && (status == ST_BAD_FORMAT || status == ST_TRUNCATED))
        |-> (frame_id == '0 && dlc_code == '0 && error_kind == EK_NONE))
        else $error("failed status carries frame fields");

    a_data_not_last_before_status: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && emit_data && end_of_message) |-> (push.count == 2'd2))
        else $error("data byte and status not pushed together");
`endif

endmodule
